// ----- design/ces_pkg.sv -----
`timescale 1ns / 1ps
// shared widths, action and kind codes for the cycle event scheduler
package ces_pkg;

    localparam int ACT_W         = 3;
    localparam int TYPE_W        = 4;
    localparam int CYC_W         = 31;
    localparam int NOW_W         = 64;
    localparam int NUM_TYPES_DEF = 16;
    localparam int MAX_FIRES     = 16;

    localparam logic [ACT_W-1:0] ACT_TICK    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SKIP    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SCHED   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_UNSCHED = 3'd3;
    localparam logic [ACT_W-1:0] ACT_QUERY   = 3'd4;

    localparam logic KIND_FIRED = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

endpackage

// ----- design/ces_if.sv -----
`timescale 1ns / 1ps
// command and result channel interfaces of the cycle event scheduler
interface ces_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [ces_pkg::ACT_W-1:0]  action;
    logic [ces_pkg::TYPE_W-1:0] event_type;
    logic [ces_pkg::CYC_W-1:0]  cycles;

    modport source (output valid, action, event_type, cycles, input ready);
    modport sink   (input valid, action, event_type, cycles, output ready);
endinterface

interface ces_res_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [ces_pkg::TYPE_W-1:0] fired_type;
    logic [ces_pkg::CYC_W-1:0]  lateness;
    logic                       pending;
    logic [ces_pkg::CYC_W-1:0]  elapsed;
    logic [ces_pkg::CYC_W-1:0]  remaining;
    logic [ces_pkg::CYC_W-1:0]  span;
    logic                       last;

    modport source (output valid, kind, fired_type, lateness, pending, elapsed, remaining,
                    span, last, input ready);
    modport sink   (input valid, kind, fired_type, lateness, pending, elapsed, remaining,
                    span, last, output ready);
endinterface

// ----- design/cycle_event_scheduler_unit.sv -----
`timescale 1ns / 1ps
// cycle event scheduler: 64-bit cycle counter with one pending slot per event type
// schedule and unschedule act in idle; a pending query: read, elapsed, remaining, span, output
// tick and skip: one slot scan per fired event plus a closing scan, which is left out once
// the fire limit is reached; a scan walks the slot memory one entry per cycle through
// a single shared 64-bit subtract unit. at most 16 events fire per transfer
// reset: async, clears counter, slot valid bits and output valid; slot memory is not cleared
module cycle_event_scheduler_unit #(
    parameter int NUM_TYPES = ces_pkg::NUM_TYPES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    ces_cmd_if.sink     cmd,
    ces_res_if.source   res
);

    localparam int IDX_W  = $clog2(NUM_TYPES);
    localparam int CNT_W  = $clog2(NUM_TYPES + 1);
    localparam int FCNT_W = $clog2(ces_pkg::MAX_FIRES + 1);
    localparam int NOW_W  = ces_pkg::NOW_W;
    localparam int CYC_W  = ces_pkg::CYC_W;
    localparam int TYPE_W = ces_pkg::TYPE_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,      // walk slots, track earliest due cycle
        ST_SCAN_END,  // scan result settled, skip moves the counter here
        ST_CHECK,     // is the earliest slot due, then hold it for output
        ST_FINAL,     // push held event with last set
        ST_QRD,
        ST_Q_EL,
        ST_Q_REM,
        ST_Q_SPAN,
        ST_Q_OUT
    } state_t;

    // saturate a wrapped 64-bit difference to 31 bits
    function automatic logic [CYC_W-1:0] sat31(input logic [NOW_W-1:0] v);
        logic [CYC_W-1:0] r;
        r = (|v[NOW_W-1:CYC_W]) ? '1 : v[CYC_W-1:0];
        return r;
    endfunction

    // slot memory: queue cycle and due cycle per type
    logic [NOW_W-1:0] mem_due    [NUM_TYPES];
    logic [NOW_W-1:0] mem_queued [NUM_TYPES];
    logic [NOW_W-1:0] rd_due_reg;
    logic [NOW_W-1:0] rd_queued_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] rd_addr;

    // control and datapath registers
    state_t            state_reg,      state_next;
    logic [NOW_W-1:0]  now_reg,        now_next;
    logic [NUM_TYPES-1:0] valid_reg,   valid_next;
    logic [CNT_W-1:0]  scan_idx_reg,   scan_idx_next;
    logic              cmp_vld_reg,    cmp_vld_next;
    logic [IDX_W-1:0]  cmp_idx_reg,    cmp_idx_next;
    logic              found_reg,      found_next;
    logic [IDX_W-1:0]  best_idx_reg,   best_idx_next;
    logic [NOW_W-1:0]  best_due_reg,   best_due_next;
    logic              skip_first_reg, skip_first_next;
    logic              hold_vld_reg,   hold_vld_next;
    logic [IDX_W-1:0]  hold_type_reg,  hold_type_next;
    logic [CYC_W-1:0]  hold_late_reg,  hold_late_next;
    logic [FCNT_W-1:0] fire_cnt_reg,   fire_cnt_next;
    logic [IDX_W-1:0]  q_idx_reg,      q_idx_next;
    logic [TYPE_W-1:0] q_type_reg,     q_type_next;
    logic              q_hit_reg,      q_hit_next;
    logic [CYC_W-1:0]  el_reg,         el_next;
    logic [CYC_W-1:0]  rem_reg,        rem_next;
    logic [CYC_W-1:0]  span_reg,       span_next;

    // output register
    logic              out_vld_reg,    out_vld_next;
    logic              out_kind_reg,   out_kind_next;
    logic [TYPE_W-1:0] out_type_reg,   out_type_next;
    logic [CYC_W-1:0]  out_late_reg,   out_late_next;
    logic              out_pend_reg,   out_pend_next;
    logic [CYC_W-1:0]  out_el_reg,     out_el_next;
    logic [CYC_W-1:0]  out_rem_reg,    out_rem_next;
    logic [CYC_W-1:0]  out_span_reg,   out_span_next;
    logic              out_last_reg,   out_last_next;

    // shared subtract unit
    logic [NOW_W-1:0]  alu_a;
    logic [NOW_W-1:0]  alu_b;
    logic [NOW_W-1:0]  alu_diff;
    logic              alu_borrow;
    logic [CYC_W-1:0]  alu_sat;

    logic              cmd_fire;
    logic              can_load;
    logic              in_range;
    logic [IDX_W-1:0]  cmd_idx;
    logic [NOW_W-1:0]  add_sum;
    logic              take;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign can_load  = !out_vld_reg || res.ready;
    assign in_range  = 32'(cmd.event_type) < 32'(NUM_TYPES);
    assign cmd_idx   = IDX_W'(cmd.event_type);
    // tick target and due cycle of a schedule share this adder
    assign add_sum   = now_reg + NOW_W'(cmd.cycles);

    assign res.valid      = out_vld_reg;
    assign res.kind       = out_kind_reg;
    assign res.fired_type = out_type_reg;
    assign res.lateness   = out_late_reg;
    assign res.pending    = out_pend_reg;
    assign res.elapsed    = out_el_reg;
    assign res.remaining  = out_rem_reg;
    assign res.span       = out_span_reg;
    assign res.last       = out_last_reg;

    // operand select of the shared unit by sequencer step
    always_comb
    begin
        case (state_reg)
            ST_SCAN:
            begin
                alu_a = rd_due_reg;
                alu_b = best_due_reg;
            end
            ST_CHECK:
            begin
                alu_a = now_reg;
                alu_b = best_due_reg;
            end
            ST_Q_EL:
            begin
                alu_a = now_reg;
                alu_b = rd_queued_reg;
            end
            ST_Q_REM:
            begin
                alu_a = rd_due_reg;
                alu_b = now_reg;
            end
            ST_Q_SPAN:
            begin
                alu_a = rd_due_reg;
                alu_b = rd_queued_reg;
            end
            default:
            begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    assign {alu_borrow, alu_diff} = {1'b0, alu_a} - {1'b0, alu_b};
    assign alu_sat = sat31(alu_diff);

    // strictly earlier due cycle wins, so lower type stays on ties
    assign take = cmp_vld_reg && valid_reg[cmp_idx_reg] && (!found_reg || alu_borrow);

    assign rd_addr = (state_reg == ST_SCAN) ? scan_idx_reg[IDX_W-1:0] : q_idx_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_due[mem_waddr]    <= add_sum;
            mem_queued[mem_waddr] <= now_reg;
        end
        rd_due_reg    <= mem_due[rd_addr];
        rd_queued_reg <= mem_queued[rd_addr];
    end

    always_comb
    begin
        state_next      = state_reg;
        now_next        = now_reg;
        valid_next      = valid_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_vld_next    = cmp_vld_reg;
        cmp_idx_next    = cmp_idx_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_due_next   = best_due_reg;
        skip_first_next = skip_first_reg;
        hold_vld_next   = hold_vld_reg;
        hold_type_next  = hold_type_reg;
        hold_late_next  = hold_late_reg;
        fire_cnt_next   = fire_cnt_reg;
        q_idx_next      = q_idx_reg;
        q_type_next     = q_type_reg;
        q_hit_next      = q_hit_reg;
        el_next         = el_reg;
        rem_next        = rem_reg;
        span_next       = span_reg;
        mem_we          = 1'b0;
        mem_waddr       = cmd_idx;

        out_vld_next  = out_vld_reg && !res.ready;
        out_kind_next = out_kind_reg;
        out_type_next = out_type_reg;
        out_late_next = out_late_reg;
        out_pend_next = out_pend_reg;
        out_el_next   = out_el_reg;
        out_rem_next  = out_rem_reg;
        out_span_next = out_span_reg;
        out_last_next = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    case (cmd.action)
                        ces_pkg::ACT_TICK, ces_pkg::ACT_SKIP:
                        begin
                            if (cmd.action == ces_pkg::ACT_TICK)
                            begin
                                now_next = add_sum;
                            end
                            skip_first_next = (cmd.action == ces_pkg::ACT_SKIP);
                            scan_idx_next   = '0;
                            cmp_vld_next    = 1'b0;
                            found_next      = 1'b0;
                            hold_vld_next   = 1'b0;
                            fire_cnt_next   = '0;
                            state_next      = ST_SCAN;
                        end
                        ces_pkg::ACT_SCHED:
                        begin
                            if (in_range)
                            begin
                                valid_next[cmd_idx] = 1'b1;
                                mem_we              = 1'b1;
                            end
                        end
                        ces_pkg::ACT_UNSCHED:
                        begin
                            if (in_range)
                            begin
                                valid_next[cmd_idx] = 1'b0;
                            end
                        end
                        ces_pkg::ACT_QUERY:
                        begin
                            q_idx_next  = cmd_idx;
                            q_type_next = cmd.event_type;
                            q_hit_next  = in_range && valid_reg[cmd_idx];
                            el_next     = '0;
                            rem_next    = '0;
                            span_next   = '0;
                            state_next  = (in_range && valid_reg[cmd_idx]) ? ST_QRD : ST_Q_OUT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // issue one read per cycle, compare in the next cycle
                if (scan_idx_reg < CNT_W'(NUM_TYPES))
                begin
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = scan_idx_reg[IDX_W-1:0];
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                else
                begin
                    cmp_vld_next = 1'b0;
                end
                if (take)
                begin
                    found_next    = 1'b1;
                    best_idx_next = cmp_idx_reg;
                    best_due_next = rd_due_reg;
                end
                if (cmp_vld_reg && (cmp_idx_reg == IDX_W'(NUM_TYPES - 1)))
                begin
                    state_next = ST_SCAN_END;
                end
            end

            ST_SCAN_END:
            begin
                if (!found_reg)
                begin
                    state_next = hold_vld_reg ? ST_FINAL : ST_IDLE;
                end
                else
                begin
                    // skip lands the counter on the earliest due cycle
                    if (skip_first_reg)
                    begin
                        now_next        = best_due_reg;
                        skip_first_next = 1'b0;
                    end
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                if (alu_borrow)
                begin
                    state_next = hold_vld_reg ? ST_FINAL : ST_IDLE;
                end
                else if (!hold_vld_reg || can_load)
                begin
                    if (hold_vld_reg)
                    begin
                        out_vld_next  = 1'b1;
                        out_kind_next = ces_pkg::KIND_FIRED;
                        out_type_next = TYPE_W'(hold_type_reg);
                        out_late_next = hold_late_reg;
                        out_pend_next = 1'b0;
                        out_el_next   = '0;
                        out_rem_next  = '0;
                        out_span_next = '0;
                        out_last_next = 1'b0;
                    end
                    hold_vld_next             = 1'b1;
                    hold_type_next            = best_idx_reg;
                    hold_late_next            = alu_sat;
                    valid_next[best_idx_reg]  = 1'b0;
                    fire_cnt_next             = fire_cnt_reg + 1'b1;
                    if (fire_cnt_reg == FCNT_W'(ces_pkg::MAX_FIRES - 1))
                    begin
                        state_next = ST_FINAL;
                    end
                    else
                    begin
                        scan_idx_next = '0;
                        cmp_vld_next  = 1'b0;
                        found_next    = 1'b0;
                        state_next    = ST_SCAN;
                    end
                end
            end

            ST_FINAL:
            begin
                if (can_load)
                begin
                    out_vld_next  = 1'b1;
                    out_kind_next = ces_pkg::KIND_FIRED;
                    out_type_next = TYPE_W'(hold_type_reg);
                    out_late_next = hold_late_reg;
                    out_pend_next = 1'b0;
                    out_el_next   = '0;
                    out_rem_next  = '0;
                    out_span_next = '0;
                    out_last_next = 1'b1;
                    hold_vld_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end

            ST_QRD:
            begin
                state_next = ST_Q_EL;
            end

            ST_Q_EL:
            begin
                el_next    = alu_sat;
                state_next = ST_Q_REM;
            end

            ST_Q_REM:
            begin
                rem_next   = alu_sat;
                state_next = ST_Q_SPAN;
            end

            ST_Q_SPAN:
            begin
                span_next  = alu_sat;
                state_next = ST_Q_OUT;
            end

            ST_Q_OUT:
            begin
                if (can_load)
                begin
                    out_vld_next  = 1'b1;
                    out_kind_next = ces_pkg::KIND_QUERY;
                    out_type_next = q_type_reg;
                    out_late_next = '0;
                    out_pend_next = q_hit_reg;
                    out_el_next   = el_reg;
                    out_rem_next  = rem_reg;
                    out_span_next = span_reg;
                    out_last_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            now_reg        <= '0;
            valid_reg      <= '0;
            scan_idx_reg   <= '0;
            cmp_vld_reg    <= 1'b0;
            cmp_idx_reg    <= '0;
            found_reg      <= 1'b0;
            best_idx_reg   <= '0;
            best_due_reg   <= '0;
            skip_first_reg <= 1'b0;
            hold_vld_reg   <= 1'b0;
            hold_type_reg  <= '0;
            hold_late_reg  <= '0;
            fire_cnt_reg   <= '0;
            q_idx_reg      <= '0;
            q_type_reg     <= '0;
            q_hit_reg      <= 1'b0;
            el_reg         <= '0;
            rem_reg        <= '0;
            span_reg       <= '0;
            out_vld_reg    <= 1'b0;
            out_kind_reg   <= 1'b0;
            out_type_reg   <= '0;
            out_late_reg   <= '0;
            out_pend_reg   <= 1'b0;
            out_el_reg     <= '0;
            out_rem_reg    <= '0;
            out_span_reg   <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            valid_reg      <= valid_next;
            scan_idx_reg   <= scan_idx_next;
            cmp_vld_reg    <= cmp_vld_next;
            cmp_idx_reg    <= cmp_idx_next;
            found_reg      <= found_next;
            best_idx_reg   <= best_idx_next;
            best_due_reg   <= best_due_next;
            skip_first_reg <= skip_first_next;
            hold_vld_reg   <= hold_vld_next;
            hold_type_reg  <= hold_type_next;
            hold_late_reg  <= hold_late_next;
            fire_cnt_reg   <= fire_cnt_next;
            q_idx_reg      <= q_idx_next;
            q_type_reg     <= q_type_next;
            q_hit_reg      <= q_hit_next;
            el_reg         <= el_next;
            rem_reg        <= rem_next;
            span_reg       <= span_next;
            out_vld_reg    <= out_vld_next;
            out_kind_reg   <= out_kind_next;
            out_type_reg   <= out_type_next;
            out_late_reg   <= out_late_next;
            out_pend_reg   <= out_pend_next;
            out_el_reg     <= out_el_next;
            out_rem_reg    <= out_rem_next;
            out_span_reg   <= out_span_next;
            out_last_reg   <= out_last_next;
        end
    end

endmodule

// ----- tb/cycle_event_scheduler_checker.sv -----
`timescale 1ns / 1ps
// checker for the cycle event scheduler: slot model, owed results and field compare
module cycle_event_scheduler_checker #(
    parameter int NUM_TYPES = ces_pkg::NUM_TYPES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    ces_cmd_if          cmd,
    ces_res_if          res,
    output int unsigned mismatch_count,
    output int unsigned owed_count
);
    import ces_pkg::*;

    localparam logic [NOW_W-1:0] SAT31 = 64'h0000_0000_7FFF_FFFF;

    typedef struct packed {
        logic              kind;
        logic [TYPE_W-1:0] fired_type;
        logic [CYC_W-1:0]  lateness;
        logic              pending;
        logic [CYC_W-1:0]  elapsed;
        logic [CYC_W-1:0]  remaining;
        logic [CYC_W-1:0]  span;
        logic              last;
    } sched_result_t;

    // model state of the scheduler
    logic [NOW_W-1:0] cur_cycle = '0;
    logic             slot_live [NUM_TYPES];
    logic [NOW_W-1:0] slot_queued [NUM_TYPES];
    logic [NOW_W-1:0] slot_due [NUM_TYPES];

    sched_result_t owed_results [$];
    int unsigned   mismatches = 0;

    assign mismatch_count = mismatches;

    function automatic logic [CYC_W-1:0] sat31(input logic [NOW_W-1:0] v);
        return (v > SAT31) ? CYC_W'(SAT31) : v[CYC_W-1:0];
    endfunction

    // earliest pending slot, lowest type on ties, -1 when none
    function automatic int earliest_slot();
        int best = -1;
        for (int i = 0; i < NUM_TYPES; i++)
        begin
            if (slot_live[i] && (best < 0 || slot_due[i] < slot_due[best]))
                best = i;
        end
        return best;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns  mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // apply one command to the model and queue the results it owes
    task automatic apply_command(input logic [ACT_W-1:0] act, input logic [TYPE_W-1:0] ty,
                                 input logic [CYC_W-1:0] cyc);
        sched_result_t batch [$];
        sched_result_t r;
        int            e;
        logic          in_range;
        in_range = (int'(ty) < NUM_TYPES);
        case (act)
            ACT_TICK:
            begin
                cur_cycle = cur_cycle + NOW_W'(cyc);
                e = earliest_slot();
                while (batch.size() < MAX_FIRES && e >= 0 && slot_due[e] <= cur_cycle)
                begin
                    slot_live[e] = 1'b0;
                    r = '0;
                    r.kind = KIND_FIRED;
                    r.fired_type = e[TYPE_W-1:0];
                    r.lateness = sat31(cur_cycle - slot_due[e]);
                    batch.insert(batch.size(), r);
                    e = earliest_slot();
                end
            end
            ACT_SKIP:
            begin
                e = earliest_slot();
                if (e >= 0)
                    cur_cycle = slot_due[e];
                while (batch.size() < MAX_FIRES && e >= 0 && slot_due[e] == cur_cycle)
                begin
                    slot_live[e] = 1'b0;
                    r = '0;
                    r.kind = KIND_FIRED;
                    r.fired_type = e[TYPE_W-1:0];
                    batch.insert(batch.size(), r);
                    e = earliest_slot();
                end
            end
            ACT_SCHED:
            begin
                if (in_range)
                begin
                    slot_live[ty] = 1'b1;
                    slot_queued[ty] = cur_cycle;
                    slot_due[ty] = cur_cycle + NOW_W'(cyc);
                end
            end
            ACT_UNSCHED:
            begin
                if (in_range)
                    slot_live[ty] = 1'b0;
            end
            ACT_QUERY:
            begin
                r = '0;
                r.kind = KIND_QUERY;
                r.fired_type = ty;
                if (in_range && slot_live[ty])
                begin
                    r.pending = 1'b1;
                    r.elapsed = sat31(cur_cycle - slot_queued[ty]);
                    r.remaining = sat31(slot_due[ty] - cur_cycle);
                    r.span = sat31(slot_due[ty] - slot_queued[ty]);
                end
                batch.insert(batch.size(), r);
            end
            default:
            begin
            end
        endcase
        if (batch.size() > 0)
            batch[batch.size()-1].last = 1'b1;
        foreach (batch[i])
            owed_results.insert(owed_results.size(), batch[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sched_result_t want;
        if (!rst_n)
        begin
            cur_cycle = '0;
            foreach (slot_live[i])
                slot_live[i] = 1'b0;
            owed_results.delete();
            owed_count <= 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (owed_results.size() == 0)
                    report_mismatch($sformatf("result of type %0d with nothing owed",
                                              res.fired_type));
                else
                begin
                    want = owed_results.pop_front();
                    if (res.kind !== want.kind)
                        report_mismatch($sformatf("kind %0b, want %0b", res.kind, want.kind));
                    if (res.fired_type !== want.fired_type)
                        report_mismatch($sformatf("type %0d, want %0d",
                                                  res.fired_type, want.fired_type));
                    if (res.lateness !== want.lateness)
                        report_mismatch($sformatf("type %0d lateness %0d, want %0d",
                                                  want.fired_type, res.lateness, want.lateness));
                    if (res.pending !== want.pending)
                        report_mismatch($sformatf("type %0d pending %0b, want %0b",
                                                  want.fired_type, res.pending, want.pending));
                    if (res.elapsed !== want.elapsed)
                        report_mismatch($sformatf("type %0d elapsed %0d, want %0d",
                                                  want.fired_type, res.elapsed, want.elapsed));
                    if (res.remaining !== want.remaining)
                        report_mismatch($sformatf("type %0d remaining %0d, want %0d",
                                                  want.fired_type, res.remaining,
                                                  want.remaining));
                    if (res.span !== want.span)
                        report_mismatch($sformatf("type %0d span %0d, want %0d",
                                                  want.fired_type, res.span, want.span));
                    if (res.last !== want.last)
                        report_mismatch($sformatf("type %0d last %0b, want %0b",
                                                  want.fired_type, res.last, want.last));
                end
            end
            if (cmd.valid && cmd.ready)
                apply_command(cmd.action, cmd.event_type, cmd.cycles);
            owed_count <= owed_results.size();
        end
    end

endmodule

// ----- tb/cycle_event_scheduler_unit_test.sv -----
`timescale 1ns / 1ps
// testbench top for the cycle event scheduler: stimulus, receiver stalls and verdict
module cycle_event_scheduler_unit_test;
    import ces_pkg::*;

    // receiver hold-off long enough to back the block up into its command input
    localparam int HOLD_CYCLES  = 300;
    // cycles without any transfer before the run is declared hung
    localparam int STALL_LIMIT  = 4000;
    // closing scan of a tick or skip that fires nothing, with margin
    localparam int DRAIN_CYCLES = 4 * (NUM_TYPES_DEF + 3);
    localparam int RANDOM_ITEMS = 150;
    // highest action code, which the block does not decode
    localparam logic [ACT_W-1:0]  ACT_TOP = '1;
    localparam logic [CYC_W-1:0]  CYC_MAX = '1;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        idle_on;
    logic        hold_go;
    logic        hold_done = 1'b0;
    int          hold_left = 0;
    int          quiet_cycles = 0;
    int          sent = 0;
    int unsigned mismatches;
    int unsigned owed;

    ces_cmd_if cmd ();
    ces_res_if res ();

    cycle_event_scheduler_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res)
    );

    // predicts and compares every result transfer
    cycle_event_scheduler_checker #(
        .NUM_TYPES (NUM_TYPES_DEF)
    ) sched_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .res            (res),
        .mismatch_count (mismatches),
        .owed_count     (owed)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // delay for a schedule: mostly short, some near ties, a few far in the future
    function automatic logic [CYC_W-1:0] pick_delay();
        int r = $urandom_range(99);
        if (r < 20)
            return CYC_W'($urandom_range(3));
        if (r < 90)
            return CYC_W'($urandom_range(300));
        return CYC_W'($urandom);
    endfunction

    // offer one command and hold it until the block takes it
    task automatic send_cmd(input logic [ACT_W-1:0] act, input logic [TYPE_W-1:0] ty,
                            input logic [CYC_W-1:0] cyc);
        // random gaps on the sender side
        while (idle_on && $urandom_range(99) < 6)
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
        cmd.valid      <= 1'b1;
        cmd.action     <= act;
        cmd.event_type <= ty;
        cmd.cycles     <= cyc;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        sent++;
    endtask

    // receiver: one long hold-off on request, otherwise random stalls while idling is on
    always @(posedge clk)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            res.ready <= 1'b0;
        end
        else if (hold_go && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            res.ready <= 1'b0;
        end
        else
            res.ready <= !(idle_on && $urandom_range(99) < 6);
    end

    // watchdog: counts cycles in which no transfer happens on either channel
    always @(posedge clk)
    begin
        if (rst_n && !((cmd.valid && cmd.ready) || (res.valid && res.ready)))
            quiet_cycles <= quiet_cycles + 1;
        else
            quiet_cycles <= 0;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("cycle_event_scheduler_unit_test: done, errors");
            $finish;
        end
    end

    initial
    begin
        int                pick;
        int                phase_start;
        int                stretch;
        logic [TYPE_W-1:0] ty;
        logic [TYPE_W-1:0] mix;
        logic [CYC_W-1:0]  base;

        rst_n           = 1'b0;
        cmd.valid      <= 1'b0;
        cmd.action     <= ACT_TICK;
        cmd.event_type <= '0;
        cmd.cycles     <= '0;
        idle_on        <= 1'b1;
        hold_go        <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle slot cases first
        send_cmd(ACT_QUERY, 4'd0, '0);          // query of an idle slot
        send_cmd(ACT_SKIP, 4'd0, '0);           // skip with nothing pending
        send_cmd(ACT_TICK, 4'd0, '0);           // tick that fires nothing
        send_cmd(ACT_UNSCHED, 4'd5, '0);        // unschedule of an idle slot
        send_cmd(ACT_TOP, 4'hF, CYC_MAX);       // undecoded action is dropped
        // longest delay, and an event due at once
        send_cmd(ACT_SCHED, 4'hF, CYC_MAX);
        send_cmd(ACT_SCHED, 4'd0, '0);
        send_cmd(ACT_QUERY, 4'd0, '0);
        send_cmd(ACT_TICK, 4'd0, '0);           // fires type 0 on time
        // reschedule replaces the slot, then a tie on the due cycle
        send_cmd(ACT_SCHED, 4'd3, 31'd10);
        send_cmd(ACT_SCHED, 4'd3, 31'd20);
        send_cmd(ACT_SCHED, 4'd7, 31'd20);
        send_cmd(ACT_TICK, 4'd0, 31'd5);
        send_cmd(ACT_QUERY, 4'd3, '0);
        send_cmd(ACT_SKIP, 4'd0, '0);           // types 3 then 7, zero lateness
        send_cmd(ACT_SCHED, 4'd9, 31'd1);
        send_cmd(ACT_UNSCHED, 4'd9, '0);
        send_cmd(ACT_QUERY, 4'd9, '0);
        // largest tick: late fires of type 10 and then the far event of type 15
        send_cmd(ACT_SCHED, 4'd10, 31'd4);
        send_cmd(ACT_TICK, 4'd0, CYC_MAX);
        send_cmd(ACT_QUERY, 4'hF, '0);

        // pressure: receiver holds off while all sixteen types fire and queries pile up
        hold_go <= 1'b1;
        mix = 4'($urandom);
        for (int i = 0; i < NUM_TYPES_DEF; i++)
            send_cmd(ACT_SCHED, TYPE_W'(i) ^ mix, '0);
        send_cmd(ACT_TICK, 4'd0, '0);
        for (int i = 0; i < 12; i++)
            send_cmd(ACT_QUERY, 4'($urandom), '0);

        // random part; the middle stretch runs with no idling on either side
        phase_start = sent;
        while (sent - phase_start < RANDOM_ITEMS)
        begin
            stretch = sent - phase_start;
            idle_on <= (stretch < 60 || stretch >= 120);
            pick = $urandom_range(99);
            ty = 4'($urandom);
            if (pick < 30)
                send_cmd(ACT_SCHED, ty, pick_delay());
            else if (pick < 50)
                send_cmd(ACT_TICK, ty,
                         ($urandom_range(9) == 0) ? CYC_W'($urandom)
                                                   : CYC_W'($urandom_range(150)));
            else if (pick < 62)
                send_cmd(ACT_SKIP, ty, CYC_W'($urandom));
            else if (pick < 80)
                send_cmd(ACT_QUERY, ty, CYC_W'($urandom));
            else if (pick < 90)
                send_cmd(ACT_UNSCHED, ty, CYC_W'($urandom));
            else if (pick < 94)
                send_cmd(ACT_W'(int'(ACT_QUERY) + 1 + $urandom_range(2)), ty, CYC_W'($urandom));
            else
            begin
                // burst: every type due near a shared base delay, then one tick or skip
                base = CYC_W'($urandom_range(20));
                mix = 4'($urandom);
                for (int i = 0; i < NUM_TYPES_DEF; i++)
                    send_cmd(ACT_SCHED, TYPE_W'(i) ^ mix, base + CYC_W'($urandom_range(2)));
                if ($urandom_range(1) == 0)
                    send_cmd(ACT_TICK, ty, base + CYC_W'(2));
                else
                    send_cmd(ACT_SKIP, ty, '0);
            end
        end
        cmd.valid <= 1'b0;

        // the owed count is registered, so it lags behind the last transfer
        @(posedge clk);
        while (owed != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("cycle_event_scheduler_unit_test: done, clean");
        else
            $display("cycle_event_scheduler_unit_test: done, errors");
        $finish;
    end

endmodule
